FILE: sv/path_collinear_point_remover_unit_macros.svh
// Assertion macros shared by the checker of the collinear point remover.
`ifndef PATH_COLLINEAR_POINT_REMOVER_UNIT_MACROS_SVH
`define PATH_COLLINEAR_POINT_REMOVER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCPR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("check failed");

// The consequent must hold in the cycle after the antecedent.
`define PCPR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("check failed");

`endif

FILE: sv/pcpr_pkg.sv
// Types, constants and the operation table of the collinear point remover.
package pcpr_pkg;

    localparam int NUM_OPS = 14;
    localparam int OP_BITS = 4;

    typedef enum logic [3:0] {
        OPND_ABX,
        OPND_ABY,
        OPND_ABZ,
        OPND_APX,
        OPND_APY,
        OPND_APZ,
        OPND_CROSS,
        OPND_TOL,
        OPND_RHS,
        OPND_TSQ
    } opnd_t;

    typedef enum logic [2:0] {
        DEST_C_LOAD,
        DEST_C_SUB,
        DEST_L_ADD,
        DEST_R_ADD,
        DEST_T_LOAD,
        DEST_R_LOAD
    } dest_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_COMMIT,
        ST_CMP,
        ST_EMIT_MID,
        ST_EMIT_LAST,
        ST_ADV
    } state_t;

    typedef struct packed {
        opnd_t a_sel;
        opnd_t b_sel;
        dest_t dest;
    } op_t;

    typedef struct packed {
        logic               load_in;
        logic               mul_en;
        logic               commit;
        logic               clr_acc;
        logic               emit_sel;
        logic               advance;
        logic [OP_BITS-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic [1:0] seen;
        logic       is_final;
        logic       degenerate;
        logic       keep;
    } status_t;

    // The three squared cross product terms, then |AB|^2, then tol^2 * |AB|^2.
    function automatic op_t op_entry(input logic [OP_BITS-1:0] idx);
        op_t r;
        case (idx)
            4'd0:    r = '{OPND_ABY, OPND_APZ, DEST_C_LOAD};
            4'd1:    r = '{OPND_ABZ, OPND_APY, DEST_C_SUB};
            4'd2:    r = '{OPND_CROSS, OPND_CROSS, DEST_L_ADD};
            4'd3:    r = '{OPND_ABZ, OPND_APX, DEST_C_LOAD};
            4'd4:    r = '{OPND_ABX, OPND_APZ, DEST_C_SUB};
            4'd5:    r = '{OPND_CROSS, OPND_CROSS, DEST_L_ADD};
            4'd6:    r = '{OPND_ABX, OPND_APY, DEST_C_LOAD};
            4'd7:    r = '{OPND_ABY, OPND_APX, DEST_C_SUB};
            4'd8:    r = '{OPND_CROSS, OPND_CROSS, DEST_L_ADD};
            4'd9:    r = '{OPND_ABX, OPND_ABX, DEST_R_ADD};
            4'd10:   r = '{OPND_ABY, OPND_ABY, DEST_R_ADD};
            4'd11:   r = '{OPND_ABZ, OPND_ABZ, DEST_R_ADD};
            4'd12:   r = '{OPND_TOL, OPND_TOL, DEST_T_LOAD};
            4'd13:   r = '{OPND_RHS, OPND_TSQ, DEST_R_LOAD};
            default: r = '{OPND_TOL, OPND_TOL, DEST_T_LOAD};
        endcase
        return r;
    endfunction

endpackage

FILE: sv/pcpr_datapath.sv
// Datapath of the collinear point remover: point store, differences and chunked multiplier.
module pcpr_datapath import pcpr_pkg::*; #(
    parameter int COORD_BITS = 20,
    parameter int MW         = 44,
    parameter int NCH        = 3,
    parameter int CHW        = 2,
    parameter int TDW        = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [TDW-1:0]         s_tdata,
    input  logic                   s_tlast,
    input  logic                   cfg_wr_en,
    input  logic [15:0]            cfg_wr_data,
    input  cmd_t                   cmd,
    input  logic [CHW-1:0]         chunk,
    output status_t                status,
    output logic [TDW-1:0]         m_tdata
);

    localparam int C  = COORD_BITS;
    localparam int D  = C + 1;
    localparam int OW = MW + 1;
    localparam int PW = 2 * MW;
    localparam int AW = PW + 2;
    localparam int BW = NCH * 16;

    logic signed [C-1:0]  in_x_reg, in_y_reg, in_z_reg;
    logic signed [C-1:0]  old_x_reg, old_y_reg, old_z_reg;
    logic signed [C-1:0]  new_x_reg, new_y_reg, new_z_reg;
    logic                 fin_reg;
    logic [1:0]           seen_reg;
    logic [15:0]          tol_reg;
    logic signed [D-1:0]  abx_reg, aby_reg, abz_reg, apx_reg, apy_reg, apz_reg;
    logic signed [OW-1:0] c_reg;
    logic [AW-1:0]        lhs_reg, rhs_reg;
    logic [MW-1:0]        tsq_reg;
    logic [PW-1:0]        prod_reg;

    logic signed [C-1:0]  px, py, pz;
    op_t                  op;
    logic [OW-1:0]        a_val, b_val;
    logic [MW-1:0]        a_mag, b_mag;
    logic [BW-1:0]        b_ext;
    logic [15:0]          b_chunk;
    logic [MW+15:0]       partial;
    logic [PW-1:0]        shifted;
    logic [AW-1:0]        p_val;
    logic                 p_neg;

    assign px = s_tdata[C-1:0];
    assign py = s_tdata[2*C-1:C];
    assign pz = s_tdata[3*C-1:2*C];
    assign op = op_entry(cmd.op);

    function automatic logic [OW-1:0] opnd_value(
        input opnd_t sel,
        input logic [D-1:0] abx, input logic [D-1:0] aby, input logic [D-1:0] abz,
        input logic [D-1:0] apx, input logic [D-1:0] apy, input logic [D-1:0] apz,
        input logic [OW-1:0] cr, input logic [15:0] tol,
        input logic [MW-1:0] rhs, input logic [MW-1:0] tsq
    );
        logic [OW-1:0] v;
        case (sel)
            OPND_ABX:   v = {{(OW-D){abx[D-1]}}, abx};
            OPND_ABY:   v = {{(OW-D){aby[D-1]}}, aby};
            OPND_ABZ:   v = {{(OW-D){abz[D-1]}}, abz};
            OPND_APX:   v = {{(OW-D){apx[D-1]}}, apx};
            OPND_APY:   v = {{(OW-D){apy[D-1]}}, apy};
            OPND_APZ:   v = {{(OW-D){apz[D-1]}}, apz};
            OPND_CROSS: v = cr;
            OPND_TOL:   v = {{(OW-16){1'b0}}, tol};
            OPND_RHS:   v = {1'b0, rhs};
            OPND_TSQ:   v = {1'b0, tsq};
            default:    v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        a_val   = opnd_value(op.a_sel, abx_reg, aby_reg, abz_reg, apx_reg, apy_reg, apz_reg,
                             c_reg, tol_reg, rhs_reg[MW-1:0], tsq_reg);
        b_val   = opnd_value(op.b_sel, abx_reg, aby_reg, abz_reg, apx_reg, apy_reg, apz_reg,
                             c_reg, tol_reg, rhs_reg[MW-1:0], tsq_reg);
        a_mag   = a_val[OW-1] ? MW'(-a_val) : a_val[MW-1:0];
        b_mag   = b_val[OW-1] ? MW'(-b_val) : b_val[MW-1:0];
        b_ext   = {{(BW-MW){1'b0}}, b_mag};
        b_chunk = b_ext[16*chunk +: 16];
        partial = {16'd0, a_mag} * {{MW{1'b0}}, b_chunk};
        shifted = {{(PW-MW-16){1'b0}}, partial} << {chunk, 4'd0};
        p_neg   = a_val[OW-1] ^ b_val[OW-1];
        p_val   = p_neg ? -{2'b00, prod_reg} : {2'b00, prod_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg  <= 2'd0;
            tol_reg   <= 16'd0;
            old_x_reg <= '0;
            old_y_reg <= '0;
            old_z_reg <= '0;
            new_x_reg <= '0;
            new_y_reg <= '0;
            new_z_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                tol_reg <= cfg_wr_data;
            end
            if (cmd.advance) begin
                if (fin_reg) begin
                    old_x_reg <= '0;
                    old_y_reg <= '0;
                    old_z_reg <= '0;
                    new_x_reg <= '0;
                    new_y_reg <= '0;
                    new_z_reg <= '0;
                    seen_reg  <= 2'd0;
                end else begin
                    old_x_reg <= new_x_reg;
                    old_y_reg <= new_y_reg;
                    old_z_reg <= new_z_reg;
                    new_x_reg <= in_x_reg;
                    new_y_reg <= in_y_reg;
                    new_z_reg <= in_z_reg;
                    if (seen_reg != 2'd2) begin
                        seen_reg <= seen_reg + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_x_reg <= px;
            in_y_reg <= py;
            in_z_reg <= pz;
            fin_reg  <= s_tlast;
            abx_reg  <= {px[C-1], px} - {old_x_reg[C-1], old_x_reg};
            aby_reg  <= {py[C-1], py} - {old_y_reg[C-1], old_y_reg};
            abz_reg  <= {pz[C-1], pz} - {old_z_reg[C-1], old_z_reg};
            apx_reg  <= {new_x_reg[C-1], new_x_reg} - {old_x_reg[C-1], old_x_reg};
            apy_reg  <= {new_y_reg[C-1], new_y_reg} - {old_y_reg[C-1], old_y_reg};
            apz_reg  <= {new_z_reg[C-1], new_z_reg} - {old_z_reg[C-1], old_z_reg};
        end
        if (cmd.clr_acc) begin
            lhs_reg <= '0;
            rhs_reg <= '0;
        end
        if (cmd.mul_en) begin
            prod_reg <= (chunk == '0) ? shifted : prod_reg + shifted;
        end
        if (cmd.commit) begin
            case (op.dest)
                DEST_C_LOAD: c_reg   <= p_val[OW-1:0];
                DEST_C_SUB:  c_reg   <= c_reg - p_val[OW-1:0];
                DEST_L_ADD:  lhs_reg <= lhs_reg + p_val;
                DEST_R_ADD:  rhs_reg <= rhs_reg + p_val;
                DEST_T_LOAD: tsq_reg <= p_val[MW-1:0];
                DEST_R_LOAD: rhs_reg <= p_val;
                default:     c_reg   <= c_reg;
            endcase
        end
    end

    assign status.seen       = seen_reg;
    assign status.is_final   = fin_reg;
    assign status.degenerate = (abx_reg == '0) && (aby_reg == '0) && (abz_reg == '0);
    assign status.keep       = lhs_reg > rhs_reg;

    always_comb begin
        m_tdata = '0;
        if (cmd.emit_sel) begin
            m_tdata[3*C-1:0] = {in_z_reg, in_y_reg, in_x_reg};
        end else begin
            m_tdata[3*C-1:0] = {new_z_reg, new_y_reg, new_x_reg};
        end
    end

endmodule

FILE: sv/pcpr_ctrl.sv
// Controller of the collinear point remover: sequences the multiply steps and the output words.
module pcpr_ctrl import pcpr_pkg::*; #(
    parameter int NCH = 3,
    parameter int CHW = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic           m_tlast,
    input  status_t        status,
    output cmd_t           cmd,
    output logic [CHW-1:0] chunk
);

    state_t               state_reg, state_next;
    logic [OP_BITS-1:0]   op_reg, op_next;
    logic [CHW-1:0]       chunk_reg, chunk_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= '0;
            chunk_reg <= '0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            chunk_reg <= chunk_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        chunk_next = chunk_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        m_tlast    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.seen == 2'd0) begin
                    state_next = status.is_final ? ST_EMIT_LAST : ST_ADV;
                end else if (status.seen == 2'd1 || status.degenerate) begin
                    state_next = ST_EMIT_MID;
                end else begin
                    cmd.clr_acc = 1'b1;
                    op_next     = '0;
                    chunk_next  = '0;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                if (chunk_reg == CHW'(NCH - 1)) begin
                    chunk_next = '0;
                    state_next = ST_COMMIT;
                end else begin
                    chunk_next = chunk_reg + 1'b1;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                if (op_reg == OP_BITS'(NUM_OPS - 1)) begin
                    state_next = ST_CMP;
                end else begin
                    op_next    = op_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_CMP: begin
                if (status.keep) begin
                    state_next = ST_EMIT_MID;
                end else begin
                    state_next = status.is_final ? ST_EMIT_LAST : ST_ADV;
                end
            end
            ST_EMIT_MID: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = status.is_final ? ST_EMIT_LAST : ST_ADV;
                end
            end
            ST_EMIT_LAST: begin
                m_tvalid     = 1'b1;
                m_tlast      = 1'b1;
                cmd.emit_sel = 1'b1;
                if (m_tready) begin
                    state_next = ST_ADV;
                end
            end
            ST_ADV: begin
                cmd.advance = 1'b1;
                state_next  = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign chunk = chunk_reg;

endmodule

FILE: sv/path_collinear_point_remover_unit.sv
// Top level of the collinear point remover for 3D paths.
// The block takes one waypoint at a time and decides each inner waypoint when its successor
// arrives, so kept points come out one word late; the first and last waypoints always pass.
// An inner waypoint is dropped when its distance to the line through its neighbours is at most
// tolerance_mm, tested exactly as |AB x AP|^2 > tol^2 * |AB|^2. One item is handled at a time:
// a waypoint that needs the distance test runs all fourteen products through one multiplier
// that consumes 16 bits of one operand per cycle; that operand is split into NCH chunks, where
// NCH = ceil(max(2 * COORD_BITS + 4, 32) / 16). Other waypoints skip the multiplier, and every
// word that the block emits waits for its output handshake.
module path_collinear_point_remover_unit import pcpr_pkg::*; #(
    parameter int COORD_BITS = 20
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]     s_tdata,   // pos_x, pos_y, pos_z
    input  logic                                  s_tlast,   // is_final
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((3*COORD_BITS+7)/8)*8-1:0]     m_tdata,   // out_x, out_y, out_z
    output logic                                  m_tlast,   // end_of_path
    input  logic                                  cfg_wr_en,
    input  logic [15:0]                           cfg_wr_data
);

    localparam int TDW = ((3 * COORD_BITS + 7) / 8) * 8;
    localparam int MW  = (2 * COORD_BITS + 4 > 32) ? 2 * COORD_BITS + 4 : 32;
    localparam int NCH = (MW + 15) / 16;
    localparam int CHW = $clog2(NCH);

    cmd_t           cmd;
    status_t        status;
    logic [CHW-1:0] chunk;

    pcpr_ctrl #(
        .NCH (NCH),
        .CHW (CHW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .status   (status),
        .cmd      (cmd),
        .chunk    (chunk)
    );

    pcpr_datapath #(
        .COORD_BITS (COORD_BITS),
        .MW         (MW),
        .NCH        (NCH),
        .CHW        (CHW),
        .TDW        (TDW)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .chunk       (chunk),
        .status      (status),
        .m_tdata     (m_tdata)
    );

endmodule

FILE: sv/pcpr_checker.sv
// Port checker for the collinear point remover and its bind to the top level.
`include "path_collinear_point_remover_unit_macros.svh"

module pcpr_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic m_tlast
);

    `PCPR_ASSERT_NEXT(a_out_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `PCPR_ASSERT_NOW(a_one_at_a_time, aclk, aresetn, s_tready, !m_tvalid)
    `PCPR_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `PCPR_ASSERT_NEXT(a_idle_after_last, aclk, aresetn, m_tvalid && m_tready && m_tlast,
                      !m_tvalid)

endmodule

bind path_collinear_point_remover_unit pcpr_checker u_pcpr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast)
);
